@@ rtl/largest_square_of_ones_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the largest-square block
// Clocked checks on clk, masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef LARGEST_SQUARE_OF_ONES_TOP_ASSERT_SVH
`define LARGEST_SQUARE_OF_ONES_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define LSQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in this cycle requires consequent in the next cycle.
`define LSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LSQ_ASSERT_ALWAYS(label, expr, msg)
`define LSQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/lsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared widths and constants for the largest-square block.
// ----------------------------------------------------------------------------
package lsq_pkg;

  localparam int SIDE_W       = 11;
  localparam int DIM_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

endpackage

@@ rtl/lsq_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_line_buf
// One-row line buffer: single write port, single registered read port.
// ----------------------------------------------------------------------------
module lsq_line_buf
  import lsq_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS,
  parameter int AW    = 10,
  parameter int DW    = SIDE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-address write lands after this read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/largest_square_of_ones_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_square_of_ones_top
// Streaming maximal-square scan over a raster of bits with a one-row buffer.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_ready    cell_req
// out      out_valid / out_ready  square_side, best_side, is_last
// cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; each item
// passes the compute stage register and then the output register. The line
// buffer is read when an item is taken and written when it leaves the compute
// stage; a read of the entry being written in the same cycle is forwarded.
// Output stalls hold the compute stage, which backs up into in_ready.
// Reset clears counters and the carried sides; the buffer needs no clearing.
module largest_square_of_ones_top
  import lsq_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cell_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SIDE_W-1:0]    square_side,
  output logic [SIDE_W-1:0]    best_side,
  output logic                 is_last
);

  `include "largest_square_of_ones_top_assert.svh"

  localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW0   = $clog2(MAX_COLS + 1);
  localparam int RW0   = $clog2(MAX_ROWS + 1);
  localparam int CW1   = (CW0 > RW0) ? CW0 : RW0;
  localparam int CMP_W = ((CW1 > DIM_W) ? CW1 : DIM_W) + 1;

  typedef struct packed {
    logic              bit_set;
    logic              c_zero;
    logic              r_zero;
    logic              row_end;
    logic              mat_end;
    logic              fwd;
    logic [CA_W-1:0]   col;
    logic [SIDE_W-1:0] fwd_side;
  } stage_t;

  logic [DIM_W-1:0]  num_cols;
  logic [DIM_W-1:0]  num_rows;
  logic [CA_W-1:0]   col_cnt;
  logic [RA_W-1:0]   row_cnt;
  logic [CMP_W-1:0]  cols_eff;
  logic [CMP_W-1:0]  rows_eff;
  logic              row_end;
  logic              mat_end;
  logic              in_acc;
  logic              s1_valid;
  logic              s1_adv;
  stage_t            s1;
  logic [SIDE_W-1:0] rd_data;
  logic [SIDE_W-1:0] left_side;
  logic [SIDE_W-1:0] diag_side;
  logic [SIDE_W-1:0] best_so_far;
  logic [SIDE_W-1:0] up_side;
  logic [SIDE_W-1:0] min_side;
  logic [SIDE_W:0]   inc_side;
  logic [SIDE_W-1:0] side_calc;
  logic [SIDE_W-1:0] best_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= DIM_RESET;
      num_rows <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLS: num_cols <= cfg_data;
        REG_NUM_ROWS: num_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp geometry into 1..MAX
  always_comb begin
    if (num_cols == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(num_cols) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(num_cols);
    end
    if (num_rows == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(num_rows) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(num_rows);
    end
  end

  assign row_end  = (CMP_W'(col_cnt) + CMP_W'(1)) >= cols_eff;
  assign mat_end  = row_end && ((CMP_W'(row_cnt) + CMP_W'(1)) >= rows_eff);
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // raster counters advance as each item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_acc) begin
      if (mat_end) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (row_end) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + RA_W'(1);
      end else begin
        col_cnt <= col_cnt + CA_W'(1);
      end
    end
  end

  lsq_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (CA_W),
    .DW    (SIDE_W)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1.col),
    .wdata (side_calc),
    .re    (in_acc),
    .raddr (col_cnt),
    .rdata (rd_data)
  );

  // compute stage: buffer read data arrives here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.bit_set  <= cell_req;
      s1.c_zero   <= (col_cnt == '0);
      s1.r_zero   <= (row_cnt == '0);
      s1.row_end  <= row_end;
      s1.mat_end  <= mat_end;
      s1.col      <= col_cnt;
      // the buffer returns the old entry when it is written this edge
      s1.fwd      <= s1_adv && (s1.col == col_cnt);
      s1.fwd_side <= side_calc;
    end
  end

  always_comb begin
    if (s1.r_zero) begin
      up_side = '0;
    end else if (s1.fwd) begin
      up_side = s1.fwd_side;
    end else begin
      up_side = rd_data;
    end
    min_side = (up_side < left_side) ? up_side : left_side;
    if (diag_side < min_side) begin
      min_side = diag_side;
    end
    inc_side = {1'b0, min_side} + (SIDE_W + 1)'(1);
    if (!s1.bit_set) begin
      side_calc = '0;
    end else if (s1.r_zero || s1.c_zero) begin
      side_calc = SIDE_W'(1);
    end else if (inc_side[SIDE_W]) begin
      side_calc = '1;
    end else begin
      side_calc = inc_side[SIDE_W-1:0];
    end
    best_next = (side_calc > best_so_far) ? side_calc : best_so_far;
  end

  // carried sides; drop them at row and matrix ends
  always_ff @(posedge clk) begin
    if (rst) begin
      left_side   <= '0;
      diag_side   <= '0;
      best_so_far <= '0;
    end else if (s1_adv) begin
      left_side   <= s1.row_end ? '0 : side_calc;
      diag_side   <= s1.row_end ? '0 : up_side;
      best_so_far <= s1.mat_end ? '0 : best_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      square_side <= side_calc;
      best_side   <= best_next;
      is_last     <= s1.mat_end;
    end
  end

  `LSQ_ASSERT_ALWAYS(a_side_le_best, !out_valid || (square_side <= best_side),
                     "square_side exceeds best_side")
  `LSQ_ASSERT_NEXT(a_restart, in_acc && mat_end, (col_cnt == '0) && (row_cnt == '0),
                   "counters not restarted after last cell")
  `LSQ_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_adv, s1_valid && $stable(s1.col),
                   "compute stage lost a stalled item")
  `LSQ_ASSERT_NEXT(a_fwd_same_col, in_acc && s1_adv && (s1.col == col_cnt),
                   s1.fwd, "missing forward on same-column access")

endmodule
